// ===== rtl/core/cagrid_pkg.sv =====
// Shared types and constants for the cellular automaton grid block.
package cagrid_pkg;

   // Grid geometry; the coordinate field widths follow the fixed item layout.
   localparam int GRID_WIDTH  = 16;
   localparam int GRID_HEIGHT = 8;
   localparam int X_W         = 4;
   localparam int Y_W         = 3;
   localparam int ROW_W       = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_ADVANCE = 2'd2
   } op_type;

   // Rule selection held in the mode register.
   localparam logic RULE_XOR  = 1'b0;
   localparam logic RULE_LIFE = 1'b1;

   typedef logic [GRID_WIDTH-1:0] row_type;

   typedef struct packed {
      op_type           operation;
      logic [X_W-1:0]   cell_x;
      logic [Y_W-1:0]   cell_y;
      logic             cell_value;
   } req_type;

   typedef struct packed {
      logic read_value;
   } rsp_type;

   typedef struct packed {
      logic rule_mode;
   } csr_type;

endpackage

// ===== rtl/core/cagrid_if.sv =====
// Valid/ready channel interfaces for requests, responses and the mode register.
interface cagrid_req_if;
   import cagrid_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cagrid_rsp_if;
   import cagrid_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cagrid_csr_if;
   import cagrid_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cellular_automaton_grid_step.sv =====
// Cellular automaton grid: one-bit cell store with write, read and generation step.
// Write and read beats complete on acceptance; a read response is registered and appears
// the cycle after acceptance, and a new beat is taken while it waits if it drains.
// An advance beat steps through every row: the shared row unit computes one row
// of the next generation per cycle while the rows rotate past it.
// Synchronous active-high reset clears every cell and selects the Life rule.
module cellular_automaton_grid_step (
   input  logic                   clock,
   input  logic                   reset,
   cagrid_req_if.sink             req,
   cagrid_rsp_if.source           rsp,
   cagrid_csr_if.sink             csr
);
   import cagrid_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_ADVANCE
   } state_type;

   state_type                 state_ff, state_in;
   row_type [GRID_HEIGHT-1:0] grid_ff, grid_in;
   row_type                   prev_ff, prev_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      rule_ff, rule_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      on_grid;
   logic                      last_row;
   row_type                   up_row, cur_row, dn_row, new_row;
   logic [GRID_WIDTH+1:0]     up_pad, cur_pad, dn_pad;
   logic [3:0]                count [GRID_WIDTH];

   // Handshakes.
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   assign on_grid = (int'(req.data.cell_x) < GRID_WIDTH) &&
                    (int'(req.data.cell_y) < GRID_HEIGHT);

   // Row unit inputs: the head row is the one being computed, the saved row is
   // the old row above it, and the next row is zero past the bottom edge.
   assign last_row = (row_ff == ROW_W'(GRID_HEIGHT - 1));
   assign up_row   = prev_ff;
   assign cur_row  = grid_ff[0];
   assign dn_row   = last_row ? '0 : grid_ff[1];
   assign up_pad   = {1'b0, up_row, 1'b0};
   assign cur_pad  = {1'b0, cur_row, 1'b0};
   assign dn_pad   = {1'b0, dn_row, 1'b0};

   // One lane per column: neighbor count and rule for the new cell value.
   always_comb begin
      for (int i = 0; i < GRID_WIDTH; i++) begin
         count[i] = 4'(up_pad[i]) + 4'(up_pad[i+1]) + 4'(up_pad[i+2])
                  + 4'(cur_pad[i]) + 4'(cur_pad[i+2])
                  + 4'(dn_pad[i]) + 4'(dn_pad[i+1]) + 4'(dn_pad[i+2]);
         if (rule_ff == RULE_LIFE) begin
            new_row[i] = (count[i] == 4'd3) || (cur_row[i] && (count[i] == 4'd2));
         end else begin
            new_row[i] = cur_row[i] ^ cur_pad[i] ^ cur_pad[i+2] ^ up_row[i] ^ dn_row[i];
         end
      end
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      grid_in      = grid_ff;
      prev_in      = prev_ff;
      row_in       = row_ff;
      rule_in      = rule_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;

      if (csr.valid) begin
         rule_in = csr.data.rule_mode;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.data.operation)
                  OP_WRITE: begin
                     if (on_grid) begin
                        grid_in[req.data.cell_y][req.data.cell_x] = req.data.cell_value;
                     end
                  end
                  OP_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.read_value =
                        on_grid && grid_ff[req.data.cell_y][req.data.cell_x];
                  end
                  OP_ADVANCE: begin
                     state_in = ST_ADVANCE;
                     row_in   = '0;
                     prev_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADVANCE: begin
            // Rotate rows up by one; the new row enters at the tail, so once every
            // row has been replaced the rows are back in order.
            for (int r = 0; r < GRID_HEIGHT - 1; r++) begin
               grid_in[r] = grid_ff[r+1];
            end
            grid_in[GRID_HEIGHT-1] = new_row;
            prev_in = cur_row;
            row_in  = row_ff + ROW_W'(1);
            if (last_row) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_ff      <= '0;
         row_ff       <= '0;
         rule_ff      <= RULE_LIFE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_ff      <= grid_in;
         row_ff       <= row_in;
         rule_ff      <= rule_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
